// ----- rtl/strc_pkg.sv -----
package strc_pkg;

    localparam int MAX_RUN     = 4096;
    localparam int ADDR_BITS   = 48;
    localparam int RUN_W       = $clog2(MAX_RUN + 1);
    localparam int PROD_W      = 16 + RUN_W;
    localparam int SUM_W       = ((PROD_W > 32) ? PROD_W : 32) + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [47:0] ADDR_MASK =
        (ADDR_BITS >= 48) ? 48'hFFFF_FFFF_FFFF : ((48'd1 << ADDR_BITS) - 48'd1);
    localparam logic [27:0] BYTES_MAX = 28'hFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_PACKET = 2'd0,
        ACT_FLUSH  = 2'd1,
        ACT_START  = 2'd2,
        ACT_DROP   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_ARRIVED = 2'd0,
        KIND_EXEC    = 2'd1,
        KIND_CORRUPT = 2'd2,
        KIND_CMD     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_ROW_BYTES   = 2'd0,
        REG_FRAME_BYTES = 2'd1,
        REG_DIRECTION   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] dst_offset;
        logic [47:0] src_addr;
        logic [15:0] row_width;
        logic [12:0] row_count;
        logic [47:0] row_pitch;
        logic [27:0] advance_bytes;
        logic [1:0]  direction;
    } cmd_t;

    typedef struct packed {
        logic  has_cmd;
        kind_t follow_kind;
        cmd_t  cmd;
    } entry_t;

    typedef struct packed {
        logic [15:0] row_bytes;
        logic [15:0] row_bytes_next;
        logic [31:0] frame_bytes;
        logic [1:0]  copy_direction;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ----- rtl/strc_front.sv -----
module strc_front
    import strc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_accept,
    input  logic [1:0]  action,
    input  logic [47:0] payload_addr,
    input  logic [15:0] payload_bytes,
    output logic        push,
    output entry_t      push_entry
);

    logic [47:0]       first_addr_reg, first_addr_next;
    logic [47:0]       last_addr_reg, last_addr_next;
    logic [RUN_W-1:0]  count_reg, count_next;
    logic [27:0]       bytes_reg, bytes_next;
    logic              locked_reg, locked_next;
    logic [47:0]       stride_reg, stride_next;
    logic [31:0]       pos_reg, pos_next;
    logic              present_reg, present_next;
    logic [PROD_W-1:0] prod_reg;

    logic [47:0]       addr_m;
    logic [47:0]       diff;
    logic              multi;
    logic              fail_m, fail_s, copy_ok;
    logic [SUM_W-1:0]  multi_end, single_end, limit;
    logic [27:0]       adv_amt;
    logic [32:0]       adv_sum;
    logic [31:0]       pos_adv;
    logic [28:0]       bytes_sum;
    logic [27:0]       bytes_sat;
    logic              bad, keep;
    cmd_t              cmd;

    assign addr_m     = payload_addr & ADDR_MASK;
    assign diff       = (addr_m - last_addr_reg) & ADDR_MASK;
    assign multi      = (count_reg > RUN_W'(1));
    assign multi_end  = SUM_W'(pos_reg) + SUM_W'(prod_reg);
    assign single_end = SUM_W'(pos_reg) + SUM_W'(cfg.row_bytes);
    assign limit      = SUM_W'(cfg.frame_bytes);
    assign fail_m     = !present_reg || (cfg.row_bytes == 16'd0) || (multi_end > limit);
    assign fail_s     = !present_reg || (cfg.row_bytes == 16'd0) || (single_end > limit);
    assign copy_ok    = multi ? !fail_m : !fail_s;
    assign adv_amt    = multi ? bytes_reg : 28'(cfg.row_bytes);
    assign adv_sum    = 33'(pos_reg) + 33'(adv_amt);
    assign pos_adv    = adv_sum[32] ? 32'hFFFF_FFFF : adv_sum[31:0];
    assign bytes_sum  = 29'(bytes_reg) + 29'(payload_bytes);
    assign bytes_sat  = bytes_sum[28] ? BYTES_MAX : bytes_sum[27:0];
    assign bad        = (addr_m == 48'd0) || (payload_bytes == 16'd0);
    assign keep       = (count_reg < RUN_W'(MAX_RUN)) && (!locked_reg || (diff == stride_reg));

    always_comb
    begin
        cmd.dst_offset    = pos_reg;
        cmd.src_addr      = first_addr_reg;
        cmd.row_width     = cfg.row_bytes;
        cmd.row_count     = multi ? 13'(count_reg) : 13'd1;
        cmd.row_pitch     = multi ? stride_reg : 48'd0;
        cmd.advance_bytes = adv_amt;
        cmd.direction     = cfg.copy_direction;
    end

    always_comb
    begin
        first_addr_next        = first_addr_reg;
        last_addr_next         = last_addr_reg;
        count_next             = count_reg;
        bytes_next             = bytes_reg;
        locked_next            = locked_reg;
        stride_next            = stride_reg;
        pos_next               = pos_reg;
        present_next           = present_reg;
        push                   = 1'b0;
        push_entry.has_cmd     = 1'b0;
        push_entry.follow_kind = KIND_CORRUPT;
        push_entry.cmd         = cmd;
        if (in_accept)
        begin
            case (action_t'(action))
                ACT_START:
                begin
                    present_next = 1'b1;
                    pos_next     = 32'd0;
                end
                ACT_DROP:
                begin
                    first_addr_next = 48'd0;
                    last_addr_next  = 48'd0;
                    count_next      = '0;
                    bytes_next      = 28'd0;
                    locked_next     = 1'b0;
                    stride_next     = 48'd0;
                end
                ACT_FLUSH:
                begin
                    push = 1'b1;
                    if (count_reg == '0)
                    begin
                        push_entry.follow_kind = KIND_EXEC;
                    end
                    else if (copy_ok || multi)
                    begin
                        push_entry.has_cmd     = copy_ok;
                        push_entry.follow_kind = copy_ok ? KIND_EXEC : KIND_CORRUPT;
                        if (copy_ok)
                        begin
                            pos_next = pos_adv;
                        end
                        first_addr_next = 48'd0;
                        last_addr_next  = 48'd0;
                        count_next      = '0;
                        bytes_next      = 28'd0;
                        locked_next     = 1'b0;
                        stride_next     = 48'd0;
                    end
                end
                ACT_PACKET:
                begin
                    push = 1'b1;
                    if (bad)
                    begin
                        push_entry.follow_kind = KIND_CORRUPT;
                    end
                    else if (count_reg == '0)
                    begin
                        push_entry.follow_kind = KIND_ARRIVED;
                        first_addr_next = addr_m;
                        last_addr_next  = addr_m;
                        count_next      = RUN_W'(1);
                        bytes_next      = 28'(payload_bytes);
                        locked_next     = 1'b0;
                        stride_next     = 48'd0;
                    end
                    else if (keep)
                    begin
                        push_entry.follow_kind = KIND_ARRIVED;
                        if (!locked_reg)
                        begin
                            stride_next = diff;
                            locked_next = 1'b1;
                        end
                        last_addr_next = addr_m;
                        count_next     = count_reg + RUN_W'(1);
                        bytes_next     = bytes_sat;
                    end
                    else if (copy_ok)
                    begin
                        push_entry.has_cmd     = 1'b1;
                        push_entry.follow_kind = KIND_ARRIVED;
                        pos_next        = pos_adv;
                        first_addr_next = addr_m;
                        last_addr_next  = addr_m;
                        count_next      = RUN_W'(1);
                        bytes_next      = 28'(payload_bytes);
                        locked_next     = 1'b0;
                        stride_next     = 48'd0;
                    end
                    else if (multi)
                    begin
                        push_entry.follow_kind = KIND_CORRUPT;
                        first_addr_next = 48'd0;
                        last_addr_next  = 48'd0;
                        count_next      = '0;
                        bytes_next      = 28'd0;
                        locked_next     = 1'b0;
                        stride_next     = 48'd0;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_addr_reg <= 48'd0;
            last_addr_reg  <= 48'd0;
            count_reg      <= '0;
            bytes_reg      <= 28'd0;
            locked_reg     <= 1'b0;
            stride_reg     <= 48'd0;
            pos_reg        <= 32'd0;
            present_reg    <= 1'b0;
            prod_reg       <= '0;
        end
        else
        begin
            first_addr_reg <= first_addr_next;
            last_addr_reg  <= last_addr_next;
            count_reg      <= count_next;
            bytes_reg      <= bytes_next;
            locked_reg     <= locked_next;
            stride_reg     <= stride_next;
            pos_reg        <= pos_next;
            present_reg    <= present_next;
            prod_reg       <= PROD_W'(cfg.row_bytes_next) * PROD_W'(count_next);
        end
    end

endmodule

// ----- rtl/strc_queue.sv -----
module strc_queue
    import strc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output qstat_t stat,
    output entry_t head
);

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/strc_back.sv -----
module strc_back
    import strc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  qstat_t       stat,
    input  entry_t       head,
    output logic         pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    logic phase_reg, phase_next;
    logic show_cmd;
    logic xfer;

    assign show_cmd = head.has_cmd && !phase_reg;
    assign m_tvalid = !stat.empty;
    assign m_tlast  = !show_cmd;
    assign m_tuser  = show_cmd ? KIND_CMD : head.follow_kind;
    assign xfer     = m_tvalid && m_tready;
    assign pop      = xfer && m_tlast;

    always_comb
    begin
        m_tdata = 192'd0;
        if (show_cmd)
        begin
            m_tdata[31:0]    = head.cmd.dst_offset;
            m_tdata[79:32]   = head.cmd.src_addr;
            m_tdata[95:80]   = head.cmd.row_width;
            m_tdata[108:96]  = head.cmd.row_count;
            m_tdata[156:109] = head.cmd.row_pitch;
            m_tdata[184:157] = head.cmd.advance_bytes;
            m_tdata[186:185] = head.cmd.direction;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (xfer)
        begin
            phase_next = show_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ----- rtl/strided_run_coalescer.sv -----
// A result is written into the queue when its input transaction is accepted, and is offered from there.
// Throughput: one input transaction per cycle while the queue has room, each updating run state.
// Output: one result per cycle while m_tready is high; copy commands precede their status.
// A four-entry queue decouples input and output; input stalls only when it is full.
// Reset: rst_n asynchronous active low; clears run and frame state and the queue,
// and returns the configuration registers to their defaults.
module strided_run_coalescer
    import strc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,  // payload_addr[47:0], payload_bytes[63:48]
    input  logic [1:0]   s_tuser,  // action[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // dst_offset[31:0], src_addr[79:32], row_width[95:80], row_count[108:96],
    // row_pitch[156:109], advance_bytes[184:157], direction[186:185], zero[191:187]
    output logic [191:0] m_tdata,
    output logic [1:0]   m_tuser,  // result_kind[1:0]
    output logic         m_tlast
);

    logic [15:0] row_bytes_reg, row_bytes_next;
    logic [31:0] frame_bytes_reg, frame_bytes_next;
    logic [1:0]  direction_reg, direction_next;
    logic        wr_en;
    reg_idx_t    reg_idx;
    cfg_t        cfg;
    logic        push, pop;
    entry_t      push_entry, head;
    qstat_t      stat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        row_bytes_next   = row_bytes_reg;
        frame_bytes_next = frame_bytes_reg;
        direction_next   = direction_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_ROW_BYTES:   row_bytes_next   = pwdata[15:0];
                REG_FRAME_BYTES: frame_bytes_next = pwdata;
                REG_DIRECTION:   direction_next   = pwdata[1:0];
                default:         direction_next   = direction_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ROW_BYTES:   prdata = 32'(row_bytes_reg);
            REG_FRAME_BYTES: prdata = frame_bytes_reg;
            REG_DIRECTION:   prdata = 32'(direction_reg);
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg   <= 16'd1;
            frame_bytes_reg <= 32'd0;
            direction_reg   <= 2'd0;
        end
        else
        begin
            row_bytes_reg   <= row_bytes_next;
            frame_bytes_reg <= frame_bytes_next;
            direction_reg   <= direction_next;
        end
    end

    assign cfg.row_bytes      = row_bytes_reg;
    assign cfg.row_bytes_next = row_bytes_next;
    assign cfg.frame_bytes    = frame_bytes_reg;
    assign cfg.copy_direction = direction_reg;

    assign s_tready = !stat.full;

    strc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_accept     (s_tvalid && s_tready),
        .action        (s_tuser),
        .payload_addr  (s_tdata[47:0]),
        .payload_bytes (s_tdata[63:48]),
        .push          (push),
        .push_entry    (push_entry)
    );

    strc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .stat       (stat),
        .head       (head)
    );

    strc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- verif/tb_strided_run_coalescer.sv -----
`timescale 1ns / 1ps

module tb_strided_run_coalescer;
    import strc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_RUN    = 100;

    typedef struct {
        kind_t       kind;
        logic [31:0] dst_offset;
        logic [47:0] src_addr;
        logic [15:0] row_width;
        logic [12:0] row_count;
        logic [47:0] row_pitch;
        logic [27:0] advance_bytes;
        logic [1:0]  direction;
        logic        last;
    } result_t;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [3:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    // register copies
    logic [15:0]  cfg_row   = 16'd1;
    logic [31:0]  cfg_frame = 32'd0;
    logic [1:0]   cfg_dir   = 2'd0;

    // run and frame tracking
    logic [47:0]  run_head   = '0;
    logic [47:0]  run_tail   = '0;
    int unsigned  run_len    = 0;
    logic [27:0]  run_sum    = '0;
    bit           stride_set = 1'b0;
    logic [47:0]  stride_val = '0;
    logic [31:0]  wr_pos     = '0;
    bit           frame_open = 1'b0;

    result_t      pending_results[$];
    int           mismatches     = 0;
    int           cycle_count    = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           hold_req       = 0;
    int           hold_left      = 0;

    strided_run_coalescer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic result_t make_result(kind_t kind, logic [31:0] dst, logic [47:0] src,
                                            logic [15:0] width, logic [12:0] rows,
                                            logic [47:0] pitch, logic [27:0] adv,
                                            logic [1:0] dir, logic last);
        result_t r;
        r.kind          = kind;
        r.dst_offset    = dst;
        r.src_addr      = src;
        r.row_width     = width;
        r.row_count     = rows;
        r.row_pitch     = pitch;
        r.advance_bytes = adv;
        r.direction     = dir;
        r.last          = last;
        return r;
    endfunction

    function automatic void push_status(kind_t kind);
        pending_results.insert(pending_results.size(),
            make_result(kind, '0, '0, '0, '0, '0, '0, '0, 1'b1));
    endfunction

    function automatic void clear_run_pred();
        run_head   = '0;
        run_tail   = '0;
        run_len    = 0;
        run_sum    = '0;
        stride_set = 1'b0;
        stride_val = '0;
    endfunction

    function automatic void start_run_pred(logic [47:0] addr, logic [15:0] nbytes);
        run_head   = addr;
        run_tail   = addr;
        run_len    = 1;
        run_sum    = 28'(nbytes);
        stride_set = 1'b0;
        stride_val = '0;
    endfunction

    function automatic void advance_pos(longint unsigned amount);
        longint unsigned p;
        p = 64'(wr_pos) + amount;
        wr_pos = (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function automatic bit copy_run_pred();
        longint unsigned pos;
        longint unsigned span;
        pos = 64'(wr_pos);
        if (run_len > 1)
        begin
            span = 64'(cfg_row) * 64'(run_len);
            if (!frame_open || cfg_row == 0 || pos + span > 64'(cfg_frame))
            begin
                clear_run_pred();
                return 1'b0;
            end
            pending_results.insert(pending_results.size(),
                make_result(KIND_CMD, wr_pos, run_head, cfg_row,
                            run_len[12:0], stride_val, run_sum, cfg_dir, 1'b0));
            advance_pos(64'(run_sum));
        end
        else
        begin
            if (!frame_open || cfg_row == 0 || pos + 64'(cfg_row) > 64'(cfg_frame))
                return 1'b0;
            pending_results.insert(pending_results.size(),
                make_result(KIND_CMD, wr_pos, run_head, cfg_row,
                            13'd1, 48'd0, 28'(cfg_row), cfg_dir, 1'b0));
            advance_pos(64'(cfg_row));
        end
        clear_run_pred();
        return 1'b1;
    endfunction

    function automatic void predict_coalescer(action_t act, logic [47:0] addr,
                                              logic [15:0] nbytes);
        logic [47:0] diff;
        bit          keep;
        logic [31:0] sum;
        case (act)
            ACT_START:
            begin
                frame_open = 1'b1;
                wr_pos     = '0;
            end
            ACT_DROP:
                clear_run_pred();
            ACT_FLUSH:
            begin
                if (run_len == 0)
                    push_status(KIND_EXEC);
                else if (!copy_run_pred())
                    push_status(KIND_CORRUPT);
                else
                    push_status(KIND_EXEC);
            end
            default:
            begin
                if (addr == 0 || nbytes == 0)
                    push_status(KIND_CORRUPT);
                else if (run_len == 0)
                begin
                    start_run_pred(addr, nbytes);
                    push_status(KIND_ARRIVED);
                end
                else
                begin
                    diff = addr - run_tail;
                    if (run_len >= MAX_RUN)
                        keep = 1'b0;
                    else if (!stride_set)
                        keep = 1'b1;
                    else
                        keep = (diff == stride_val);
                    if (keep)
                    begin
                        if (!stride_set)
                        begin
                            stride_val = diff;
                            stride_set = 1'b1;
                        end
                        run_tail = addr;
                        run_len++;
                        sum = 32'(run_sum) + 32'(nbytes);
                        run_sum = (sum > 32'(BYTES_MAX)) ? BYTES_MAX : sum[27:0];
                        push_status(KIND_ARRIVED);
                    end
                    else if (!copy_run_pred())
                        push_status(KIND_CORRUPT);
                    else
                    begin
                        start_run_pred(addr, nbytes);
                        push_status(KIND_ARRIVED);
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result_kind: expected none, got %0h", m_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result_kind", 64'(want.kind), 64'(m_tuser));
                check_field("dst_offset", 64'(want.dst_offset), 64'(m_tdata[31:0]));
                check_field("src_addr", 64'(want.src_addr), 64'(m_tdata[79:32]));
                check_field("row_width", 64'(want.row_width), 64'(m_tdata[95:80]));
                check_field("row_count", 64'(want.row_count), 64'(m_tdata[108:96]));
                check_field("row_pitch", 64'(want.row_pitch), 64'(m_tdata[156:109]));
                check_field("advance_bytes", 64'(want.advance_bytes),
                            64'(m_tdata[184:157]));
                check_field("direction", 64'(want.direction), 64'(m_tdata[186:185]));
                check_field("last", 64'(want.last), 64'(m_tlast));
            end
        end
    end

    task automatic send_item(action_t act, logic [47:0] addr, logic [15:0] nbytes);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {nbytes, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_coalescer(act, addr, nbytes);
    endtask

    // hold the input idle until every result is out, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ROW_BYTES:   cfg_row   = value[15:0];
            REG_FRAME_BYTES: cfg_frame = value;
            REG_DIRECTION:   cfg_dir   = value[1:0];
            default:         ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(logic [15:0] row, logic [31:0] frame, logic [1:0] dir);
        drain();
        write_reg(REG_ROW_BYTES, 32'(row));
        write_reg(REG_FRAME_BYTES, frame);
        write_reg(REG_DIRECTION, 32'(dir));
    endtask

    task automatic random_traffic(int count);
        int          sent;
        int          len;
        logic [47:0] addr;
        logic [47:0] stride;
        logic [15:0] nbytes;
        int          pick;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                addr = 48'({$urandom, $urandom});
                case ($urandom_range(0, 4))
                    0: stride = 48'($urandom_range(1, 64));
                    1: stride = 48'(cfg_row);
                    2: stride = 48'({$urandom, $urandom});
                    3: stride = 48'd0;
                    default: stride = -48'($urandom_range(1, 4096));
                endcase
                len = $urandom_range(1, 12);
                if ($urandom_range(0, 3) == 0)
                begin
                    send_item(ACT_START, 48'({$urandom, $urandom}), 16'($urandom));
                    sent++;
                end
                for (int i = 0; i < len; i++)
                begin
                    nbytes = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                         : 16'($urandom_range(1, 1500));
                    // break the stride now and then
                    if (i > 1 && $urandom_range(0, 11) == 0)
                        addr = addr ^ 48'($urandom_range(1, 255));
                    send_item(ACT_PACKET, addr, nbytes);
                    sent++;
                    addr = addr + stride;
                end
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    send_item(ACT_FLUSH, 48'({$urandom, $urandom}), 16'($urandom));
                    sent++;
                end
                else if (pick >= 85)
                begin
                    send_item(ACT_DROP, 48'({$urandom, $urandom}), 16'($urandom));
                    sent++;
                end
            end
            else
            begin
                addr   = ($urandom_range(0, 3) == 0) ? 48'd0 : 48'({$urandom, $urandom});
                nbytes = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
                send_item(action_t'($urandom_range(0, 3)), addr, nbytes);
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        send_item(ACT_FLUSH, 48'd0, 16'd0);
        send_item(ACT_PACKET, 48'd0, 16'd64);
        send_item(ACT_PACKET, 48'h1000, 16'd0);
        send_item(ACT_PACKET, 48'h1000, 16'd100);
        send_item(ACT_FLUSH, 48'd0, 16'd0);
        send_item(ACT_START, 48'd0, 16'd0);
        send_item(ACT_FLUSH, 48'd0, 16'd0);
        set_config(16'd16, 32'd4096, 2'd3);
        send_item(ACT_FLUSH, 48'd0, 16'd0);
        send_item(ACT_PACKET, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
        send_item(ACT_PACKET, 48'h10, 16'd1);
        send_item(ACT_PACKET, 48'h21, 16'd2);
        send_item(ACT_PACKET, 48'h40, 16'd3);
        send_item(ACT_DROP, 48'd0, 16'd0);
        send_item(ACT_FLUSH, 48'd0, 16'd0);
        send_item(ACT_START, 48'd0, 16'd0);
        send_item(ACT_PACKET, 48'h100, 16'd10);
        send_item(ACT_PACKET, 48'h100, 16'd10);
        send_item(ACT_PACKET, 48'h100, 16'd10);
        send_item(ACT_FLUSH, 48'd0, 16'd0);
        set_config(16'd16, 32'd64, 2'd1);
        send_item(ACT_START, 48'd0, 16'd0);
        for (int i = 0; i < 5; i++)
            send_item(ACT_PACKET, 48'h2000 + 48'(8 * i), 16'd8);
        send_item(ACT_FLUSH, 48'd0, 16'd0);
        for (int i = 0; i < 4; i++)
            send_item(ACT_PACKET, 48'h3000 + 48'(8 * i), 16'd8);
        send_item(ACT_FLUSH, 48'd0, 16'd0);
        send_item(ACT_PACKET, 48'h4000, 16'd8);
        send_item(ACT_FLUSH, 48'd0, 16'd0);
        set_config(16'd0, 32'd4096, 2'd0);
        send_item(ACT_START, 48'd0, 16'd0);
        send_item(ACT_PACKET, 48'h5000, 16'd8);
        send_item(ACT_FLUSH, 48'd0, 16'd0);
        send_item(ACT_FLUSH, 48'd0, 16'd0);
    endtask

    // one long run at a fixed stride, then a lone packet
    task automatic test_long_run();
        set_config(16'd1, 32'hFFFF_FFFF, 2'd2);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(ACT_START, 48'd0, 16'd0);
        for (int i = 0; i < LONG_RUN; i++)
            send_item(ACT_PACKET, 48'h1000 + 48'h10000 * 48'(i), 16'hFFFF);
        send_item(ACT_FLUSH, 48'd0, 16'd0);
        send_item(ACT_PACKET, 48'h7777_0000, 16'd1);
        send_item(ACT_FLUSH, 48'd0, 16'd0);
        send_item(ACT_DROP, 48'd0, 16'd0);
    endtask

    task automatic test_back_pressure();
        set_config(16'd32, 32'hFFFF_FFFF, 2'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(ACT_START, 48'd0, 16'd0);
        hold_req = 150;
        random_traffic(40);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_config(16'd1, 32'hFFFF_FFFF, 2'd0);
                1: set_config(16'hFFFF, 32'hFFFF_FFFF, 2'd1);
                2: set_config(16'd64, 32'd30000, 2'd2);
                3: set_config(16'($urandom_range(1, 65535)), $urandom, 2'd3);
                4: set_config(16'd0, $urandom, 2'($urandom));
                5: set_config(16'($urandom_range(1, 512)), 32'd0, 2'($urandom));
                6: set_config(16'd16, 32'h0010_0000, 2'($urandom));
                default: set_config(16'($urandom_range(1, 65535)), 32'hFFFF_FFFF,
                                    2'($urandom));
            endcase
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 48;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 48;
                end
                default:
                begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            send_item(ACT_START, 48'd0, 16'd0);
            random_traffic(80);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_long_run();
        test_back_pressure();
        test_random_phases();
        drain();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/strc_pkg.sv
rtl/strc_front.sv
rtl/strc_queue.sv
rtl/strc_back.sv
rtl/strided_run_coalescer.sv
verif/tb_strided_run_coalescer.sv
